// ===== rtl/core/chs_pkg.sv =====
// chs_pkg: shared constants and the pipeline word type of the chs geometry block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package chs_pkg;

	localparam int MAX_END_CYL  = 1021;
	localparam int MAX_HEAD_IDX = 254;
	localparam int MAX_CYL_SIZE = 255 * 63;
	localparam int LBA_W        = 33;
	localparam int LEN_W        = 48;

	// one word travelling down the pipeline; later stages fill later fields
	typedef struct packed {
		logic               ok;
		logic [9:0]         sc;
		logic [9:0]         ec;
		logic [7:0]         sh;
		logic [7:0]         eh;
		logic signed [6:0]  ss;
		logic signed [6:0]  es;
		logic [LBA_W-1:0]   sa;
		logic [LBA_W-1:0]   ea;
		logic signed [34:0] sas;
		logic signed [34:0] eas;
		logic [17:0]        dp0;
		logic [17:0]        dp1;
		logic signed [43:0] np0;
		logic signed [43:0] np1;
		logic [17:0]        absd;
		logic [43:0]        absn;
		logic [31:0]        rem;
		logic [13:0]        csz;
		logic signed [35:0] hn;
		logic [7:0]         hd;
		logic [13:0]        hrem;
		logic [5:0]         hsz;
		logic [13:0]        crem;
		logic [7:0]         heads;
		logic [17:0]        xs;
		logic [17:0]        xe;
		logic [17:0]        pp;
		logic [47:0]        dq;
		logic [14:0]        dr;
	} pipe_t;

endpackage

// ===== rtl/core/chs_if.sv =====
// chs_if: valid/ready channel interfaces for entry words, geometry words and config
// depends on nothing; payload widths follow the partition entry layout
`timescale 1ns / 1ps

interface chs_entry_if;
	logic        valid;
	logic        ready;
	logic        has_original;
	logic [7:0]  start_head;
	logic [7:0]  start_sector_byte;
	logic [7:0]  start_cylinder_low;
	logic [7:0]  last_head;
	logic [7:0]  end_sector_byte;
	logic [7:0]  end_cylinder_low;
	logic [32:0] start_lba;
	logic [32:0] end_lba;
	modport source (output valid, has_original, start_head, start_sector_byte,
		start_cylinder_low, last_head, end_sector_byte, end_cylinder_low,
		start_lba, end_lba, input ready);
	modport sink (input valid, has_original, start_head, start_sector_byte,
		start_cylinder_low, last_head, end_sector_byte, end_cylinder_low,
		start_lba, end_lba, output ready);
endinterface

interface chs_geom_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [47:0] cylinders;
	logic [7:0]  heads;
	logic [5:0]  sectors;
	modport source (output valid, found, cylinders, heads, sectors, input ready);
	modport sink (input valid, found, cylinders, heads, sectors, output ready);
endinterface

interface chs_cfg_if;
	logic        valid;
	logic        ready;
	logic [47:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/chs_solve.sv =====
// chs_solve: solves the 2x2 corner system for cylinder size, ten pipeline stages
// depends on chs_pkg; restoring divider two quotient bits per stage
`timescale 1ns / 1ps

module chs_solve import chs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_v,
	input  pipe_t in_p,
	output logic  out_v,
	output pipe_t out_p
);

	localparam int DIV_ST = 7;

	pipe_t d1, d2, d3;
	pipe_t st_s1, st_s2, st_s3;
	logic  v_s1, v_s2, v_s3;
	pipe_t div_s [DIV_ST];
	logic  div_v [DIV_ST];

	// range checks and the four cross products
	always_comb begin
		logic [23:0] lim;
		lim = (24'(in_p.ec) + 24'd1) * 24'(MAX_CYL_SIZE);
		d1 = in_p;
		d1.ok = in_p.ok && (in_p.sh <= 8'(MAX_HEAD_IDX)) && (in_p.eh <= 8'(MAX_HEAD_IDX))
			&& (in_p.sc <= in_p.ec) && (in_p.ea <= {9'd0, lim})
			&& (in_p.ec <= 10'(MAX_END_CYL)) && (in_p.ec != 10'd0);
		d1.dp0 = 18'(in_p.sc) * 18'(in_p.eh);
		d1.dp1 = 18'(in_p.ec) * 18'(in_p.sh);
		d1.np0 = 44'(in_p.sas) * $signed({36'd0, in_p.eh});
		d1.np1 = 44'(in_p.eas) * $signed({36'd0, in_p.sh});
	end

	// determinant and numerator, reduced to magnitudes with a common sign
	always_comb begin
		logic signed [19:0] den;
		logic signed [43:0] num;
		den = $signed({2'b0, st_s1.dp0}) - $signed({2'b0, st_s1.dp1});
		num = st_s1.np0 - st_s1.np1;
		d2 = st_s1;
		d2.ok = st_s1.ok && (den != 20'sd0) && (num != 44'sd0) && (den[19] == num[43]);
		d2.absd = den[19] ? 18'(-den) : 18'(den);
		d2.absn = num[43] ? 44'(-num) : 44'(num);
	end

	// quotient must not exceed the largest cylinder size
	always_comb begin
		logic [31:0] bound;
		bound = 32'(st_s2.absd) * 32'(MAX_CYL_SIZE);
		d3 = st_s2;
		d3.ok = st_s2.ok && (st_s2.absn <= {12'd0, bound});
		d3.rem = st_s2.absn[31:0];
		d3.csz = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= d1;
			st_s2 <= d2;
			st_s3 <= d3;
		end
	end

	for (genvar g = 0; g < DIV_ST; g++) begin : g_div
		pipe_t pin, pd;
		logic  vin;
		if (g == 0) begin : g_first
			assign pin = st_s3;
			assign vin = v_s3;
		end else begin : g_rest
			assign pin = div_s[g-1];
			assign vin = div_v[g-1];
		end

		always_comb begin
			logic [31:0] sub;
			pd = pin;
			for (int j = 0; j < 2; j++) begin
				sub = 32'(pin.absd) << (13 - 2 * g - j);
				if (pd.rem >= sub) begin
					pd.rem = pd.rem - sub;
					pd.csz[13 - 2 * g - j] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v[g] <= 1'b0;
			end else if (en) begin
				div_v[g] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[g] <= pd;
			end
		end
	end

	assign out_v = div_v[DIV_ST-1];
	assign out_p = div_s[DIV_ST-1];

endmodule

// ===== rtl/core/chs_check.sv =====
// chs_check: head size, heads and both corner checks, nine pipeline stages
// depends on chs_pkg; follows chs_solve in the pipeline
`timescale 1ns / 1ps

module chs_check import chs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_v,
	input  pipe_t in_p,
	output logic  out_v,
	output pipe_t out_p
);

	localparam int NST = 9;

	pipe_t st_s [NST];
	logic  v_s  [NST];
	pipe_t d    [NST];

	// exact cylinder size, then head size numerator from a corner with nonzero head
	always_comb begin
		d[0] = in_p;
		d[0].ok = in_p.ok && (in_p.rem == 32'd0) && (in_p.csz != 14'd0);
		if (in_p.sh != 8'd0) begin
			d[0].hn = 36'(in_p.sas) - $signed({12'd0, 24'(in_p.sc) * 24'(in_p.csz)});
			d[0].hd = in_p.sh;
		end else if (in_p.eh != 8'd0) begin
			d[0].hn = 36'(in_p.eas) - $signed({12'd0, 24'(in_p.ec) * 24'(in_p.csz)});
			d[0].hd = in_p.eh;
		end else begin
			d[0].hn = '0;
			d[0].hd = 8'd1;
			d[0].ok = 1'b0;
		end
	end

	// head size must land in 1..63
	always_comb begin
		d[1] = st_s[0];
		d[1].ok = st_s[0].ok && (st_s[0].hn >= $signed({28'd0, st_s[0].hd}))
			&& (st_s[0].hn < $signed({22'd0, st_s[0].hd, 6'd0}));
		d[1].hrem = st_s[0].hn[13:0];
		d[1].hsz = '0;
	end

	for (genvar g = 0; g < 2; g++) begin : g_hdiv
		always_comb begin
			logic [13:0] sub;
			d[2+g] = st_s[1+g];
			for (int j = 0; j < 3; j++) begin
				sub = 14'(st_s[1+g].hd) << (5 - 3 * g - j);
				if (d[2+g].hrem >= sub) begin
					d[2+g].hrem = d[2+g].hrem - sub;
					d[2+g].hsz[5 - 3 * g - j] = 1'b1;
				end
			end
		end
	end

	// heads must land in 1..255
	always_comb begin
		d[4] = st_s[3];
		d[4].ok = st_s[3].ok && (st_s[3].csz >= 14'(st_s[3].hsz))
			&& (st_s[3].csz < {st_s[3].hsz, 8'd0});
		d[4].crem = st_s[3].csz;
		d[4].heads = '0;
	end

	for (genvar g = 0; g < 2; g++) begin : g_ndiv
		always_comb begin
			logic [13:0] sub;
			d[5+g] = st_s[4+g];
			for (int j = 0; j < 4; j++) begin
				sub = 14'(st_s[4+g].hsz) << (7 - 4 * g - j);
				if (d[5+g].crem >= sub) begin
					d[5+g].crem = d[5+g].crem - sub;
					d[5+g].heads[7 - 4 * g - j] = 1'b1;
				end
			end
		end
	end

	always_comb begin
		d[7] = st_s[6];
		d[7].xs = 18'(st_s[6].sc) * 18'(st_s[6].heads) + 18'(st_s[6].sh);
		d[7].xe = 18'(st_s[6].ec) * 18'(st_s[6].heads) + 18'(st_s[6].eh);
		d[7].pp = 18'(st_s[6].heads) * 18'(st_s[6].hsz);
	end

	// corner checks; end corner may sit one cylinder further out
	always_comb begin
		logic signed [25:0] ys, ye, ye1;
		ys  = $signed(26'(st_s[7].xs) * 26'(st_s[7].hsz)) + 26'(st_s[7].ss);
		ye  = $signed(26'(st_s[7].xe) * 26'(st_s[7].hsz)) + 26'(st_s[7].es);
		ye1 = ye + $signed(26'(st_s[7].pp));
		d[8] = st_s[7];
		d[8].ok = st_s[7].ok && (34'(ys) == $signed({1'b0, st_s[7].sa}))
			&& ((34'(ye) == $signed({1'b0, st_s[7].ea}))
			|| (34'(ye1) == $signed({1'b0, st_s[7].ea})));
	end

	for (genvar g = 0; g < NST; g++) begin : g_reg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= (g == 0) ? in_v : v_s[(g == 0) ? 0 : g-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[g] <= d[g];
			end
		end
	end

	assign out_v = v_s[NST-1];
	assign out_p = st_s[NST-1];

endmodule

// ===== rtl/core/chs_cdiv.sv =====
// chs_cdiv: disk length over cylinder size, restoring divider in eight stages
// depends on chs_pkg; six quotient bits per stage, follows chs_check
`timescale 1ns / 1ps

module chs_cdiv import chs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [LEN_W-1:0] disk_length,
	input  logic             in_v,
	input  pipe_t            in_p,
	output logic             out_v,
	output pipe_t            out_p
);

	localparam int NST = 8;
	localparam int BPS = 6;

	pipe_t st_s [NST];
	logic  v_s  [NST];

	for (genvar g = 0; g < NST; g++) begin : g_st
		pipe_t pin, pd;
		logic  vin;
		if (g == 0) begin : g_first
			always_comb begin
				pin = in_p;
				pin.dq = disk_length;
				pin.dr = '0;
			end
			assign vin = in_v;
		end else begin : g_rest
			assign pin = st_s[g-1];
			assign vin = v_s[g-1];
		end

		always_comb begin
			logic [14:0] r;
			pd = pin;
			for (int j = 0; j < BPS; j++) begin
				r = {pd.dr[13:0], pd.dq[47]};
				pd.dq = {pd.dq[46:0], 1'b0};
				if (r >= {1'b0, pd.csz}) begin
					r = r - {1'b0, pd.csz};
					pd.dq[0] = 1'b1;
				end
				pd.dr = r;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= vin;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[g] <= pd;
			end
		end
	end

	assign out_v = v_s[NST-1];
	assign out_p = st_s[NST-1];

endmodule

// ===== rtl/core/chs_geometry_infer.sv =====
// chs_geometry_infer: entry word to geometry word through chs_solve, chs_check, chs_cdiv and an output register
// throughput one word per cycle; the whole pipeline advances together and holds
// while the output register waits; the dividers yield 14 + 6 + 8 + 48 quotient bits
// arst_n clears all valid bits and disk_length to 0; payload is not reset
// depends on chs_pkg, chs_if, chs_solve, chs_check, chs_cdiv
`timescale 1ns / 1ps

module chs_geometry_infer import chs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	chs_cfg_if.sink    cfg,
	chs_entry_if.sink  entry,
	chs_geom_if.source geom
);

	logic [LEN_W-1:0] disk_length_q;
	logic             en;
	pipe_t            p0, p_sol, p_chk, p_div;
	logic             v_sol, v_chk, v_div;
	logic             out_v_q;
	logic             found_q;
	logic [47:0]      cylinders_q;
	logic [7:0]       heads_q;
	logic [5:0]       sectors_q;

	// config register, always ready; user must ensure it is only written while the pipe is empty (unenforced)
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_length_q <= '0;
		end else if (cfg.valid) begin
			disk_length_q <= cfg.data;
		end
	end

	// the pipeline moves whenever the output register is free or being drained
	assign en          = !out_v_q || geom.ready;
	assign entry.ready = en;

	// unpack both chs corners: 10-bit cylinder, head, 0-based sector
	always_comb begin
		p0 = '0;
		p0.ok  = entry.has_original;
		p0.sh  = entry.start_head;
		p0.eh  = entry.last_head;
		p0.sc  = {entry.start_sector_byte[7:6], entry.start_cylinder_low};
		p0.ec  = {entry.end_sector_byte[7:6], entry.end_cylinder_low};
		// a sector field of zero becomes -1 and is carried through as such
		p0.ss  = $signed({1'b0, entry.start_sector_byte[5:0]}) - 7'sd1;
		p0.es  = $signed({1'b0, entry.end_sector_byte[5:0]}) - 7'sd1;
		p0.sa  = entry.start_lba;
		p0.ea  = entry.end_lba;
		p0.sas = $signed({2'b0, entry.start_lba}) - 35'(p0.ss);
		p0.eas = $signed({2'b0, entry.end_lba}) - 35'(p0.es);
	end

	// cylinder size from the linear system
	chs_solve u_solve (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (entry.valid),
		.in_p   (p0),
		.out_v  (v_sol),
		.out_p  (p_sol)
	);

	// head size, heads, corner verification
	chs_check u_check (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_sol),
		.in_p   (p_sol),
		.out_v  (v_chk),
		.out_p  (p_chk)
	);

	// cylinder count from the device length
	chs_cdiv u_cdiv (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.disk_length (disk_length_q),
		.in_v        (v_chk),
		.in_p        (p_chk),
		.out_v       (v_div),
		.out_p       (p_div)
	);

	// output register; a failed solve reports all fields zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= v_div;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			found_q     <= p_div.ok;
			cylinders_q <= p_div.ok ? p_div.dq : '0;
			heads_q     <= p_div.ok ? p_div.heads : '0;
			sectors_q   <= p_div.ok ? p_div.hsz : '0;
		end
	end

	assign geom.valid     = out_v_q;
	assign geom.found     = found_q;
	assign geom.cylinders = cylinders_q;
	assign geom.heads     = heads_q;
	assign geom.sectors   = sectors_q;

	// not found means all geometry fields are zero
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !found_q) |-> (cylinders_q == '0 && heads_q == '0 && sectors_q == '0))
		else $error("not-found word carries nonzero geometry");

	// a found geometry never has zero heads or sectors
	a_nonzero_geom: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && found_q) |-> (heads_q != 8'd0 && sectors_q != 6'd0))
		else $error("found geometry with zero heads or sectors");

	// cylinder count cannot exceed the device length
	a_cyl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && found_q) |-> (cylinders_q <= disk_length_q))
		else $error("cylinder count above disk length");

endmodule
